@@ rtl/core/bpa_pkg.sv @@
package bpa_pkg;

  // block geometry
  localparam int BLOCK_BYTES      = 4096;
  localparam int BLK_SHIFT        = $clog2(BLOCK_BYTES);
  localparam int BLK_NUM_W        = 32 - BLK_SHIFT;
  localparam int BITMAP_WORDS_DEF = 1024;

  // scan limit register
  localparam int              WIU_W     = 11;
  localparam logic [WIU_W-1:0] WIU_RESET = 11'd1024;

  localparam logic [31:0] FULL_WORD = 32'hffff_ffff;

  // request kinds
  typedef enum logic [1:0] {
    KIND_ALLOC     = 2'd0,
    KIND_FREE      = 2'd1,
    KIND_MARK_USED = 2'd2,
    KIND_MARK_FREE = 2'd3
  } kind_e;

  // controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_READ,
    S_A_CHECK,
    S_F_CHECK,
    S_F_READ,
    S_F_WRITE,
    S_M_SETUP,
    S_M_SEG,
    S_M_READ,
    S_M_WRITE,
    S_FINISH
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic ptr_clear;
    logic ptr_inc;
    logic ptr_free;
    logic ptr_seg;
    logic rd_en;
    logic wr_clear;
    logic wr_alloc;
    logic wr_free;
    logic wr_mark;
    logic seg_first;
    logic seg_second;
    logic res_ok;
    logic res_alloc;
    logic out_load;
  } bpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e in_kind;
    logic  clr_last;
    logic  lim_zero;
    logic  scan_last;
    logic  word_full;
    logic  misaligned;
    logic  beyond_cap;
    logic  seg_empty;
    logic  seg_more;
    logic  word_last;
    logic  out_busy;
  } bpa_status_t;

endpackage

@@ rtl/core/bpa_ctrl.sv @@
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  bpa_status_t status_i,
  output bpa_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.in_kind)
            KIND_ALLOC:                    state_d = S_A_READ;
            KIND_FREE:                     state_d = S_F_CHECK;
            KIND_MARK_USED, KIND_MARK_FREE: state_d = S_M_SETUP;
            default:                       state_d = S_IDLE;
          endcase
        end
      end
      S_A_READ: begin
        state_d = status_i.lim_zero ? S_FINISH : S_A_CHECK;
      end
      S_A_CHECK: begin
        if (!status_i.word_full || status_i.scan_last) state_d = S_FINISH;
        else state_d = S_A_READ;
      end
      S_F_CHECK: begin
        if (status_i.misaligned || status_i.beyond_cap) state_d = S_FINISH;
        else state_d = S_F_READ;
      end
      S_F_READ:  state_d = S_F_WRITE;
      S_F_WRITE: state_d = S_FINISH;
      S_M_SETUP: state_d = S_M_SEG;
      S_M_SEG: begin
        if (!status_i.seg_empty) state_d = S_M_READ;
        else if (!status_i.seg_more) state_d = S_FINISH;
      end
      S_M_READ: state_d = S_M_WRITE;
      S_M_WRITE: begin
        if (!status_i.word_last) state_d = S_M_READ;
        else if (status_i.seg_more) state_d = S_M_SEG;
        else state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!status_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.ptr_inc  = !status_i.clr_last;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req  = 1'b1;
          cmd_o.ptr_clear = 1'b1;
        end
      end
      S_A_READ: begin
        cmd_o.rd_en = !status_i.lim_zero;
      end
      S_A_CHECK: begin
        if (!status_i.word_full) begin
          cmd_o.wr_alloc  = 1'b1;
          cmd_o.res_alloc = 1'b1;
        end else if (!status_i.scan_last) begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_F_CHECK: begin
        cmd_o.ptr_free = 1'b1;
        cmd_o.res_ok   = !status_i.misaligned && status_i.beyond_cap;
      end
      S_F_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      S_F_WRITE: begin
        cmd_o.wr_free = 1'b1;
        cmd_o.res_ok  = 1'b1;
      end
      S_M_SETUP: begin
        cmd_o.seg_first = 1'b1;
        cmd_o.res_ok    = 1'b1;
      end
      S_M_SEG: begin
        if (!status_i.seg_empty) cmd_o.ptr_seg = 1'b1;
        else cmd_o.seg_second = status_i.seg_more;
      end
      S_M_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      S_M_WRITE: begin
        cmd_o.wr_mark = 1'b1;
        if (!status_i.word_last) cmd_o.ptr_inc = 1'b1;
        else cmd_o.seg_second = status_i.seg_more;
      end
      S_FINISH: begin
        cmd_o.out_load = !status_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/bpa_datapath.sv @@
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      address_i,
  input  logic [31:0]      length_i,
  input  logic             cfg_we_i,
  input  logic [WIU_W-1:0] cfg_wdata_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [31:0]      block_address_o,
  output logic             success_o,
  input  bpa_cmd_t         cmd_i,
  output bpa_status_t      status_o
);

  localparam int WAW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int BIW    = (BLK_NUM_W > WAW + 5) ? BLK_NUM_W : WAW + 5;
  localparam int CNT_W  = $clog2(BITMAP_WORDS + 1);
  localparam int LIM_W  = (CNT_W > WIU_W) ? CNT_W : WIU_W;
  localparam logic [BIW-1:0]   CAP_LAST  = BIW'(BITMAP_WORDS * 32 - 1);
  localparam logic [WAW-1:0]   WORD_LAST = WAW'(BITMAP_WORDS - 1);
  localparam logic [LIM_W-1:0] CAP_WORDS = LIM_W'(BITMAP_WORDS);

  // bitmap memory
  logic [31:0] mem [BITMAP_WORDS];
  logic [31:0] rdata_q;
  logic [31:0] wdata;
  logic        we;

  logic [WIU_W-1:0] wiu_q;
  logic [1:0]       req_kind_q;
  logic [31:0]      req_addr_q, req_len_q;
  logic [WAW-1:0]   wptr_q;
  logic [BIW-1:0]   seg_lo_q, seg_hi_q;
  logic             seg_more_q;
  logic [31:0]      res_addr_q;
  logic             res_ok_q;
  logic             out_valid_q;
  logic [31:0]      out_addr_q;
  logic             out_ok_q;

  // scan limit
  logic [LIM_W-1:0] wiu_ext, limit;
  assign wiu_ext = LIM_W'(wiu_q);
  assign limit   = (wiu_ext < CAP_WORDS) ? wiu_ext : CAP_WORDS;

  // range bounds in blocks
  logic [31:0]    end_addr;
  logic [BIW-1:0] first_blk, last_blk, last_clip;
  logic           wrap;
  assign end_addr  = req_addr_q + req_len_q;
  assign first_blk = BIW'(req_addr_q[31:BLK_SHIFT]);
  assign last_blk  = BIW'(end_addr[31:BLK_SHIFT]);
  assign last_clip = (last_blk > CAP_LAST) ? CAP_LAST : last_blk;
  assign wrap      = (last_blk < first_blk);

  // lowest free bit of the word just read
  logic [4:0] free_bit;
  always_comb begin
    free_bit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!rdata_q[i]) free_bit = 5'(i);
    end
  end

  logic [WAW+4:0] alloc_blk;
  logic [31:0]    alloc_addr;
  assign alloc_blk  = {wptr_q, free_bit};
  assign alloc_addr = 32'({alloc_blk, {BLK_SHIFT{1'b0}}});

  // mark mask for the current word
  logic [4:0]  lo_bit, hi_bit;
  logic [31:0] mark_mask;
  logic        at_lo_word, at_hi_word;
  assign at_lo_word = (wptr_q == seg_lo_q[WAW+4:5]);
  assign at_hi_word = (wptr_q == seg_hi_q[WAW+4:5]);
  assign lo_bit     = at_lo_word ? seg_lo_q[4:0] : 5'd0;
  assign hi_bit     = at_hi_word ? seg_hi_q[4:0] : 5'd31;
  assign mark_mask  = (FULL_WORD >> (5'd31 - hi_bit)) & (FULL_WORD << lo_bit);

  logic [31:0] free_mask;
  assign free_mask = 32'd1 << req_addr_q[BLK_SHIFT+4:BLK_SHIFT];

  // write data select
  always_comb begin
    we    = cmd_i.wr_clear | cmd_i.wr_alloc | cmd_i.wr_free | cmd_i.wr_mark;
    wdata = rdata_q;
    priority if (cmd_i.wr_clear) begin
      wdata = '0;
    end else if (cmd_i.wr_alloc) begin
      wdata = rdata_q | (32'd1 << free_bit);
    end else if (cmd_i.wr_free) begin
      wdata = rdata_q & ~free_mask;
    end else if (cmd_i.wr_mark) begin
      if (req_kind_q == KIND_MARK_USED) wdata = rdata_q | mark_mask;
      else wdata = rdata_q & ~mark_mask;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wptr_q] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[wptr_q];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wiu_q       <= WIU_RESET;
      wptr_q      <= '0;
      seg_more_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) wiu_q <= cfg_wdata_i;
      priority if (cmd_i.ptr_clear) wptr_q <= '0;
      else if (cmd_i.ptr_inc)       wptr_q <= wptr_q + 1'b1;
      else if (cmd_i.ptr_free)      wptr_q <= first_blk[WAW+4:5];
      else if (cmd_i.ptr_seg)       wptr_q <= seg_lo_q[WAW+4:5];
      if (cmd_i.seg_first)       seg_more_q <= wrap;
      else if (cmd_i.seg_second) seg_more_q <= 1'b0;
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // request, segment and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_kind_q <= kind_i;
      req_addr_q <= address_i;
      req_len_q  <= length_i;
      res_addr_q <= '0;
      res_ok_q   <= 1'b0;
    end
    if (cmd_i.res_ok) res_ok_q <= 1'b1;
    if (cmd_i.res_alloc) begin
      res_addr_q <= alloc_addr;
      res_ok_q   <= 1'b1;
    end
    if (cmd_i.seg_first) begin
      seg_lo_q <= first_blk;
      seg_hi_q <= wrap ? CAP_LAST : last_clip;
    end else if (cmd_i.seg_second) begin
      seg_lo_q <= '0;
      seg_hi_q <= last_clip;
    end
    if (cmd_i.out_load) begin
      out_addr_q <= res_addr_q;
      out_ok_q   <= res_ok_q;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.in_kind    = kind_e'(kind_i);
    status_o.clr_last   = (wptr_q == WORD_LAST);
    status_o.lim_zero   = (limit == '0);
    status_o.scan_last  = (LIM_W'(wptr_q) == limit - LIM_W'(1));
    status_o.word_full  = (rdata_q == FULL_WORD);
    status_o.misaligned = (req_addr_q[BLK_SHIFT-1:0] != '0);
    status_o.beyond_cap = (first_blk > CAP_LAST);
    status_o.seg_empty  = (seg_lo_q > seg_hi_q);
    status_o.seg_more   = seg_more_q;
    status_o.word_last  = at_hi_word;
    status_o.out_busy   = out_valid_q & out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign success_o       = out_ok_q;

endmodule

@@ rtl/core/bitmap_page_allocator.sv @@
// First-fit bitmap allocator for fixed-size physical blocks, one usage bit per block.
// Request channel: in_valid_i / in_stall_o carry kind_i, address_i and length_i
// (allocate, free one block, mark a range used, mark a range free).
// Result channel: out_valid_o / out_stall_i carry block_address_o and success_o,
// exactly one result per request, in request order.
// Config: cfg_we_i writes cfg_wdata_i into the scan limit in words (reset 1024).
// Steps per request: allocate reads then checks scanned words in turn, and
// skips the scan with a zero scan limit; free checks the address, then reads
// and writes its word, and skips both when misaligned or beyond capacity; a
// range mark sets up, then reads and writes each touched word, and walks a
// second segment from block zero when the range wraps. Each word that changes
// goes through a read then a write on the single memory; one request is worked
// at a time. After reset a clearing pass writes every bitmap word to free, with
// in_stall_o high; config writes are taken meanwhile.
// The result sits in an output register, so the next request is accepted while
// it waits; if the receiver keeps stalling, the following result holds in the
// finish state until the output register is taken.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int BITMAP_WORDS = BITMAP_WORDS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [31:0]      address_i,
  input  logic [31:0]      length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      block_address_o,
  output logic             success_o,
  input  logic             cfg_we_i,
  input  logic [WIU_W-1:0] cfg_wdata_i
);

  bpa_cmd_t    cmd;
  bpa_status_t status;

  // sequencer
  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // bitmap storage and arithmetic
  bpa_datapath #(
    .BITMAP_WORDS (BITMAP_WORDS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kind_i          (kind_i),
    .address_i       (address_i),
    .length_i        (length_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .block_address_o (block_address_o),
    .success_o       (success_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

@@ test/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int          CAP_BLOCKS  = BITMAP_WORDS_DEF * 32;
  localparam int          TOP_BLOCK   = (1 << BLK_NUM_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 8_000_000;

  typedef struct {
    kind_e       kind;
    logic [31:0] addr;
    logic [31:0] len;
  } alloc_req_t;

  typedef struct packed {
    logic [31:0] block_addr;
    logic        ok;
  } alloc_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [1:0]       kind_i      = '0;
  logic [31:0]      address_i   = '0;
  logic [31:0]      length_i    = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [31:0]      block_address_o;
  logic             success_o;
  logic             cfg_we_i    = 1'b0;
  logic [WIU_W-1:0] cfg_wdata_i = '0;

  // testbench copy of the allocator state
  logic [31:0]      usage_map [BITMAP_WORDS_DEF];
  logic [WIU_W-1:0] scan_words = WIU_RESET;

  alloc_req_t    request_queue[$];
  alloc_result_t predicted_results[$];
  int unsigned   sent_cnt   = 0;
  int unsigned   acc_cnt    = 0;
  int unsigned   err_cnt    = 0;
  int unsigned   cycle_cnt  = 0;
  int unsigned   idle_pct   = 0;
  int unsigned   stall_pct  = 0;

  bitmap_page_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .address_i      (address_i),
    .length_i       (length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .block_address_o(block_address_o),
    .success_o      (success_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // set or clear blocks lo..hi inclusive, clipped to capacity
  function automatic void mark_blocks(longint unsigned lo, longint unsigned hi, logic used);
    if (hi >= CAP_BLOCKS) hi = CAP_BLOCKS - 1;
    for (longint unsigned b = lo; b <= hi; b++) usage_map[b / 32][b % 32] = used;
  endfunction

  // expected reply for one request, updating the bitmap copy
  task automatic serve_request(input kind_e kind, input logic [31:0] addr,
                               input logic [31:0] len, output logic [31:0] got_addr,
                               output logic ok);
    int unsigned     limit;
    longint unsigned blk;
    longint unsigned first;
    longint unsigned last;
    logic [31:0]     end_addr;
    got_addr = '0;
    ok       = 1'b0;
    case (kind)
      KIND_ALLOC: begin
        limit = (scan_words > BITMAP_WORDS_DEF) ? BITMAP_WORDS_DEF : scan_words;
        for (int w = 0; w < limit && !ok; w++) begin
          if (usage_map[w] != FULL_WORD) begin
            for (int j = 0; j < 32 && !ok; j++) begin
              if (!usage_map[w][j]) begin
                usage_map[w][j] = 1'b1;
                blk      = w * 32 + j;
                got_addr = 32'(blk << BLK_SHIFT);
                ok       = 1'b1;
              end
            end
          end
        end
      end
      KIND_FREE: begin
        if (addr[BLK_SHIFT-1:0] == '0) begin
          blk = addr >> BLK_SHIFT;
          if (blk < CAP_BLOCKS) usage_map[blk / 32][blk % 32] = 1'b0;
          ok = 1'b1;
        end
      end
      default: begin
        end_addr = addr + len;
        first    = addr >> BLK_SHIFT;
        last     = end_addr >> BLK_SHIFT;
        if (last >= first) begin
          mark_blocks(first, last, kind == KIND_MARK_USED);
        end else begin
          // wrapped range: top part first, then from block zero
          mark_blocks(first, CAP_BLOCKS - 1, kind == KIND_MARK_USED);
          mark_blocks(0, last, kind == KIND_MARK_USED);
        end
        ok = 1'b1;
      end
    endcase
  endtask

  function automatic logic [31:0] block_base(int unsigned lo_blk, int unsigned hi_blk);
    return 32'($urandom_range(hi_blk, lo_blk)) << BLK_SHIFT;
  endfunction

  // random request, biased to the low blocks where allocation happens
  function automatic alloc_req_t rand_req();
    alloc_req_t  r;
    int unsigned pick;
    int unsigned sel;
    pick   = $urandom_range(99);
    sel    = $urandom_range(99);
    r.addr = $urandom;
    r.len  = $urandom;
    if (pick < 35) begin
      r.kind = KIND_ALLOC;
    end else if (pick < 65) begin
      r.kind = KIND_FREE;
      if (sel < 60)      r.addr = block_base(0, 255);
      else if (sel < 75) r.addr = block_base(0, CAP_BLOCKS - 1);
      else if (sel < 85) r.addr = block_base(0, 255) | 32'($urandom_range(4095, 1));
      else if (sel < 93) r.addr = block_base(CAP_BLOCKS, TOP_BLOCK);
    end else begin
      r.kind = (pick < 80) ? KIND_MARK_USED : KIND_MARK_FREE;
      if (sel < 80) begin
        r.addr = block_base(0, 255);
        if ($urandom_range(1)) r.addr |= 32'($urandom_range(4095));
        r.len = 32'($urandom_range(16 << BLK_SHIFT));
      end else if (sel < 90) begin
        // range that wraps past the top of the address space
        if ($urandom_range(1)) r.addr = block_base(TOP_BLOCK - 15, TOP_BLOCK);
        else                   r.addr = block_base(CAP_BLOCKS - 40, CAP_BLOCKS - 1);
        r.addr |= 32'($urandom_range(4095));
        r.len   = (32'h0 - r.addr) + 32'($urandom_range(8 << BLK_SHIFT));
      end else if (sel < 96) begin
        r.addr = block_base(0, CAP_BLOCKS - 1) | 32'($urandom_range(4095));
        r.len  = 32'($urandom_range(64 << BLK_SHIFT));
      end
    end
    return r;
  endfunction

  task automatic push_req(kind_e kind, logic [31:0] addr, logic [31:0] len);
    request_queue.push_back('{kind, addr, len});
  endtask

  task automatic push_random(int unsigned n);
    repeat (n) request_queue.push_back(rand_req());
  endtask

  // wait until every request is taken and every reply is back
  task automatic drain();
    while (request_queue.size() != 0 || sent_cnt != acc_cnt || predicted_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_scan_limit(logic [WIU_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // request driver
  always @(negedge clk_i) begin : drive_requests
    alloc_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (sent_cnt == acc_cnt) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = request_queue.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= nxt.kind;
        address_i  <= nxt.addr;
        length_i   <= nxt.len;
        sent_cnt++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // acceptance, config tracking and reply checking
  always @(posedge clk_i) begin : watch_ports
    logic [31:0]   pred_addr;
    logic          pred_ok;
    alloc_result_t want;
    cycle_cnt++;
    if (rst_ni) begin
      if (cfg_we_i) scan_words = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        serve_request(kind_e'(kind_i), address_i, length_i, pred_addr, pred_ok);
        predicted_results.push_back('{pred_addr, pred_ok});
        acc_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected reply: addr %h ok %b", block_address_o, success_o);
        end else begin
          want = predicted_results.pop_front();
          if (block_address_o !== want.block_addr || success_o !== want.ok) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected addr %h ok %b, got addr %h ok %b",
                       want.block_addr, want.ok, block_address_o, success_o);
          end
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    for (int i = 0; i < BITMAP_WORDS_DEF; i++) usage_map[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed requests at the reset scan limit, no idling
    idle_pct  = 0;
    stall_pct = 0;
    push_req(KIND_ALLOC, 32'h0, 32'h0);                     // block zero
    push_req(KIND_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_FREE, 32'h0000_0000, 32'h0);
    push_req(KIND_FREE, 32'h0000_0001, 32'h0);              // misaligned
    push_req(KIND_FREE, 32'hFFFF_F000, 32'h0);              // beyond capacity
    push_req(KIND_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_MARK_USED, 32'h0, 32'h0);
    push_req(KIND_MARK_USED, 32'h0000_1000, 32'h0001_F000);
    push_req(KIND_ALLOC, 32'h0, 32'h0);
    push_req(KIND_MARK_FREE, 32'h0, 32'hFFFF_FFFF);
    push_req(KIND_MARK_USED, 32'hFFFF_F000, 32'h0000_2000); // wraps, top beyond capacity
    push_req(KIND_MARK_USED, 32'h07FF_F000, 32'h0);         // last block
    push_req(KIND_MARK_USED, 32'h07FF_E000, 32'hF800_3000); // wraps inside capacity
    push_req(KIND_ALLOC, 32'h0, 32'h0);
    push_req(KIND_FREE, 32'h0000_2000, 32'h0);
    push_req(KIND_MARK_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(KIND_MARK_FREE, 32'h0, 32'h7FFF_FFFF);
    push_req(KIND_ALLOC, 32'h0, 32'h0);
    drain();

    // zero scan limit, sender idles
    write_scan_limit(WIU_W'(0));
    idle_pct = 57;
    push_req(KIND_ALLOC, 32'h0, 32'h0);
    push_req(KIND_ALLOC, 32'h0, 32'h0);
    push_random(40);
    drain();

    // scan limit above capacity, receiver stalls
    write_scan_limit(WIU_W'(2047));
    idle_pct  = 0;
    stall_pct = 57;
    push_req(KIND_MARK_USED, 32'h0, 32'h07FF_FFFF);         // fill everything
    push_req(KIND_ALLOC, 32'h0, 32'h0);
    push_req(KIND_MARK_FREE, 32'h07FF_F000, 32'h0);
    push_req(KIND_ALLOC, 32'h0, 32'h0);                     // top block
    push_req(KIND_FREE, 32'h07FF_F000, 32'h0);
    push_req(KIND_MARK_FREE, 32'h0, 32'h07FF_FFFF);
    push_random(150);
    drain();

    // single scanned word, light traffic on both sides
    write_scan_limit(WIU_W'(1));
    idle_pct  = 7;
    stall_pct = 7;
    push_req(KIND_MARK_FREE, 32'h0, 32'h07FF_FFFF);
    push_random(100);
    drain();

    // small pool, no idling
    write_scan_limit(WIU_W'(3));
    idle_pct  = 0;
    stall_pct = 0;
    push_random(150);
    drain();

    // full bitmap again, sender idles
    write_scan_limit(WIU_W'(1024));
    idle_pct = 57;
    push_random(80);
    drain();

    // mid-size pool, receiver stalls
    write_scan_limit(WIU_W'(40));
    idle_pct  = 0;
    stall_pct = 57;
    push_random(80);
    drain();

    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && predicted_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/bpa_pkg.sv
rtl/core/bpa_ctrl.sv
rtl/core/bpa_datapath.sv
rtl/core/bitmap_page_allocator.sv
test/bitmap_page_allocator_tb.sv
